/* rtl/dpp_pkg.sv */
// shared types and constants of the depth to point projection block
package dpp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_Z_GAIN       = 3'd0;
  localparam logic [2:0] REG_FX_INVERSE   = 3'd1;
  localparam logic [2:0] REG_FY_INVERSE   = 3'd2;
  localparam logic [2:0] REG_CENTER_X     = 3'd3;
  localparam logic [2:0] REG_CENTER_Y     = 3'd4;
  localparam logic [2:0] REG_DISPLAY_GAIN = 3'd5;

  // configuration reset values
  localparam logic [31:0] Z_GAIN_RST       = 32'd137439;
  localparam logic [31:0] FX_INVERSE_RST   = 32'd9258612;
  localparam logic [31:0] FY_INVERSE_RST   = 32'd9258612;
  localparam logic [15:0] CENTER_X_RST     = 16'd5120;
  localparam logic [15:0] CENTER_Y_RST     = 16'd3840;
  localparam logic [31:0] DISPLAY_GAIN_RST = 32'd29205778;

  // saturation limits of the signed Q16.16 coordinates
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // brightest display level
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

/* rtl/dpp_axis.sv */
// one projection axis: offset from center, scale by depth, saturate
module dpp_axis #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                    clk,
  input  dpp_pkg::stage_en_t      en,
  input  logic [COORD_WIDTH-1:0]  coord,
  input  logic [15:0]             center,
  input  logic [31:0]             inv,
  input  logic [31:0]             zq,
  output logic signed [31:0]      result
);

  localparam int POS_W = COORD_WIDTH + 4;
  localparam int OFF_W = (POS_W > 16) ? POS_W : 16;
  localparam int MAG_W = OFF_W + 28;
  localparam logic [MAG_W-1:0] MAG_POS = MAG_W'(dpp_pkg::SAT_POS);
  localparam logic [MAG_W-1:0] MAG_NEG = MAG_W'(dpp_pkg::SAT_NEG);

  logic [OFF_W-1:0]    pos;
  logic [OFF_W-1:0]    cen;
  logic                neg;
  logic [OFF_W-1:0]    off;
  logic [63:0]         scale_prod;
  logic [OFF_W+31:0]   mag_prod;
  logic [31:0]         lim;
  logic [31:0]         res_nxt;

  logic                neg1_r, neg2_r, neg3_r;
  logic [OFF_W-1:0]    off1_r, off2_r;
  logic [31:0]         scale2_r;
  logic [MAG_W-1:0]    mag3_r;
  logic [31:0]         res4_r;

  // signed Q12.4 offset split into sign and magnitude
  assign pos = OFF_W'({coord, 4'b0000});
  assign cen = OFF_W'(center);
  assign neg = pos < cen;
  assign off = neg ? (cen - pos) : (pos - cen);

  // depth times reciprocal focal length, then offset times that scale
  assign scale_prod = 64'(zq) * 64'(inv);
  assign mag_prod   = (OFF_W + 32)'(off2_r) * (OFF_W + 32)'(scale2_r);

  // saturate the magnitude and apply the sign
  always_comb begin
    if (neg3_r) begin
      lim     = (mag3_r > MAG_NEG) ? dpp_pkg::SAT_NEG : mag3_r[31:0];
      res_nxt = 32'd0 - lim;
    end else begin
      lim     = (mag3_r > MAG_POS) ? dpp_pkg::SAT_POS : mag3_r[31:0];
      res_nxt = lim;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en.s1) begin
      neg1_r <= neg;
      off1_r <= off;
    end
    if (en.s2) begin
      neg2_r   <= neg1_r;
      off2_r   <= off1_r;
      scale2_r <= scale_prod[63:32];
    end
    if (en.s3) begin
      neg3_r <= neg2_r;
      mag3_r <= mag_prod[OFF_W+31:4];
    end
    if (en.s4) begin
      res4_r <= res_nxt;
    end
  end

  assign result = res4_r;

endmodule

/* rtl/depth_to_point_projection_core.sv */
// top level of the depth sample to 3-D point projection pipeline
//
// Each input request carries one raw depth sample with its pixel column
// and row; each output request carries the back-projected point (x, y, z
// in Q16.16 meters, saturated), a point valid flag and a display grey
// level. A raw value of zero yields an invalid point with all zero fields.
// The pipeline has four register stages: the depth products, the scale
// products (32 by 32 multipliers), the offset products and the output
// register. One sample is taken every cycle while in_stall is low; each
// axis has one multiplier in its scale stage and one in its offset stage.
// When the receiver stalls, stages that hold an item stop while bubbles
// ahead of them still close up; in_stall rises only when every stage is
// full. Reset empties the pipeline and loads the default camera settings.
// The configuration port is always ready; the user must write it only
// while idle, and the block itself does not enforce this.
module depth_to_point_projection_core #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [15:0]            in_depth_raw,
  input  logic [COORD_WIDTH-1:0] in_pixel_col,
  input  logic [COORD_WIDTH-1:0] in_pixel_row,
  // point channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_point_x,
  output logic signed [31:0]     out_point_y,
  output logic [30:0]            out_point_z,
  output logic                   out_point_valid,
  output logic [7:0]             out_display_level,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  logic [31:0] z_gain_r, fx_inverse_r, fy_inverse_r, display_gain_r;
  logic [15:0] center_x_r, center_y_r;

  dpp_pkg::stage_en_t en;
  logic adv1, adv2, adv3, adv4;
  logic v1_r, v2_r, v3_r, out_valid_r;

  logic [47:0] zp1_r, dp1_r;
  logic        nz1_r, nz2_r, nz3_r;
  logic [31:0] zq1;
  logic [30:0] zout2_nxt, zout2_r, zout3_r, zout4_r;
  logic [16:0] ceil_lvl;
  logic [7:0]  level2_nxt, level2_r, level3_r, level4_r;
  logic        nz4_r;
  logic signed [31:0] x_res, y_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_gain_r       <= dpp_pkg::Z_GAIN_RST;
      fx_inverse_r   <= dpp_pkg::FX_INVERSE_RST;
      fy_inverse_r   <= dpp_pkg::FY_INVERSE_RST;
      center_x_r     <= dpp_pkg::CENTER_X_RST;
      center_y_r     <= dpp_pkg::CENTER_Y_RST;
      display_gain_r <= dpp_pkg::DISPLAY_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpp_pkg::REG_Z_GAIN:       z_gain_r       <= cfg_data;
        dpp_pkg::REG_FX_INVERSE:   fx_inverse_r   <= cfg_data;
        dpp_pkg::REG_FY_INVERSE:   fy_inverse_r   <= cfg_data;
        dpp_pkg::REG_CENTER_X:     center_x_r     <= cfg_data[15:0];
        dpp_pkg::REG_CENTER_Y:     center_y_r     <= cfg_data[15:0];
        dpp_pkg::REG_DISPLAY_GAIN: display_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when empty or when the next one moves
  assign adv4 = !out_valid_r || !out_stall;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  assign en.s1 = adv1;
  assign en.s2 = adv2;
  assign en.s3 = adv3;
  assign en.s4 = adv4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) out_valid_r <= v3_r;
    end
  end

  // depth in Q16.16 and clamped z
  assign zq1       = zp1_r[47:16];
  assign zout2_nxt = zq1[31] ? dpp_pkg::SAT_POS[30:0] : zq1[30:0];

  // display level: 255 minus the rounded-up product, clamped at zero; zero for a zero depth
  assign ceil_lvl   = 17'(dp1_r[47:32]) + 17'(|dp1_r[31:0]);
  assign level2_nxt = !nz1_r ? 8'd0 :
                      (ceil_lvl < 17'(dpp_pkg::LEVEL_MAX)) ?
                      (dpp_pkg::LEVEL_MAX - ceil_lvl[7:0]) : 8'd0;

  // depth and display path registers
  always_ff @(posedge clk) begin
    if (en.s1) begin
      zp1_r <= 48'(in_depth_raw) * 48'(z_gain_r);
      dp1_r <= 48'(in_depth_raw) * 48'(display_gain_r);
      nz1_r <= |in_depth_raw;
    end
    if (en.s2) begin
      zout2_r  <= zout2_nxt;
      level2_r <= level2_nxt;
      nz2_r    <= nz1_r;
    end
    if (en.s3) begin
      zout3_r  <= zout2_r;
      level3_r <= level2_r;
      nz3_r    <= nz2_r;
    end
    if (en.s4) begin
      zout4_r  <= zout3_r;
      level4_r <= level3_r;
      nz4_r    <= nz3_r;
    end
  end

  // horizontal and vertical axes
  dpp_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
    .clk    (clk),
    .en     (en),
    .coord  (in_pixel_col),
    .center (center_x_r),
    .inv    (fx_inverse_r),
    .zq     (zq1),
    .result (x_res)
  );

  dpp_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
    .clk    (clk),
    .en     (en),
    .coord  (in_pixel_row),
    .center (center_y_r),
    .inv    (fy_inverse_r),
    .zq     (zq1),
    .result (y_res)
  );

  // outputs
  assign out_valid         = out_valid_r;
  assign out_point_x       = x_res;
  assign out_point_y       = y_res;
  assign out_point_z       = zout4_r;
  assign out_point_valid   = nz4_r;
  assign out_display_level = level4_r;

endmodule

/* rtl/dpp_checker.sv */
// port-level checks of the projection core and their binding
module dpp_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [31:0]     out_point_x,
  input logic signed [31:0]     out_point_y,
  input logic [30:0]            out_point_z,
  input logic                   out_point_valid,
  input logic [7:0]             out_display_level
);

  // an invalid point carries all zero fields
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |->
      (out_point_x == 32'sd0 && out_point_y == 32'sd0 &&
       out_point_z == 31'd0 && out_display_level == 8'd0))
    else $error("invalid point with nonzero fields");

  // zero depth leaves no lateral offset
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_point_z == 31'd0) |->
      (out_point_x == 32'sd0 && out_point_y == 32'sd0))
    else $error("lateral offset at zero depth");

  // the input never stalls while the output register can move
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled with a free pipeline");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_point_x) && $stable(out_point_y) &&
       $stable(out_point_z) && $stable(out_point_valid) &&
       $stable(out_display_level)))
    else $error("stalled result changed");

endmodule

bind depth_to_point_projection_core dpp_checker u_dpp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_point_x       (out_point_x),
  .out_point_y       (out_point_y),
  .out_point_z       (out_point_z),
  .out_point_valid   (out_point_valid),
  .out_display_level (out_display_level)
);
